// ----- rtl/crc32c_stream_assert.svh -----
// Assertion macros for the CRC-32C stream design files; crcs_fifo.sv uses them.
`ifndef CRC32C_STREAM_ASSERT_SVH
`define CRC32C_STREAM_ASSERT_SVH

// Holds in the same cycle as the condition, outside reset.
`define CRCS_ASSERT_NOW(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error(msg);

// Holds in the cycle after the condition, outside reset.
`define CRCS_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ----- rtl/crcs_pkg.sv -----
// Shared constants, types and CRC-32C tables for the CRC-32C stream design.
package crcs_pkg;

  localparam logic [31:0] CrcPoly   = 32'h82F6_3B78;
  localparam logic [31:0] CrcInvert = 32'hFFFF_FFFF;

  // Widest item the datapath tables are built for, and the default item size.
  localparam int BytesMax        = 8;
  localparam int BytesPerItemDef = 8;
  localparam int QueueDepthDef   = 2;

  localparam int DataWidth  = 64;
  localparam int CountWidth = 4;

  typedef logic [255:0][31:0]               crc_table_t;
  typedef logic [BytesMax:0][31:0][31:0]    zero_mat_t;

  // One request after the front end: the CRC of its data bytes from a zero
  // register, the number of bytes absorbed and the seed for a first item.
  typedef struct packed {
    logic [31:0]           data_crc;
    logic [CountWidth-1:0] nbytes;
    logic                  first;
    logic [31:0]           seed;
    logic                  last;
  } crcs_item_t;

  typedef struct packed {
    logic [31:0] crc;
    logic        last;
  } crcs_result_t;

  function automatic crc_table_t build_crc_table();
    crc_table_t  tab;
    logic [31:0] r;
    for (int i = 0; i < 256; i++) begin
      r = 32'(i);
      for (int b = 0; b < 8; b++) begin
        r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
      end
      tab[i] = r;
    end
    return tab;
  endfunction

  // Column j of entry n is the register bit j after n zero bytes.
  function automatic zero_mat_t build_zero_mat();
    zero_mat_t   mat;
    logic [31:0] r;
    for (int n = 0; n <= BytesMax; n++) begin
      for (int j = 0; j < 32; j++) begin
        r = 32'h1 << j;
        for (int b = 0; b < 8 * n; b++) begin
          r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
        end
        mat[n][j] = r;
      end
    end
    return mat;
  endfunction

  localparam crc_table_t CrcTable = build_crc_table();
  localparam zero_mat_t  ZeroMat  = build_zero_mat();

  // Advances a register over n zero bytes: an XOR tree over its set bits.
  function automatic logic [31:0] zero_shift(logic [CountWidth-1:0] n, logic [31:0] r);
    logic [31:0] acc;
    acc = '0;
    for (int j = 0; j < 32; j++) begin
      if (r[j]) begin
        acc = acc ^ ZeroMat[n][j];
      end
    end
    return acc;
  endfunction

endpackage

// ----- rtl/crcs_fifo.sv -----
// Small synchronous queue with full and empty flags.
module crcs_fifo
  import crcs_pkg::*;
#(
  parameter int Width = 8,
  parameter int Depth = QueueDepthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  `include "crc32c_stream_assert.svh"

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `CRCS_ASSERT_NOW(a_no_overflow, push_i && !pop_i, !full_o, "push into a full queue")
  `CRCS_ASSERT_NOW(a_no_underflow, pop_i, !empty_o, "pop from an empty queue")
  `CRCS_ASSERT_NEXT(a_ptr_gap, 1'b1,
                    (cnt_q == CntW'(Depth)) || (cnt_q == '0) || (wr_ptr_q != rd_ptr_q),
                    "queue pointers disagree with the fill count")

endmodule

// ----- rtl/crcs_front.sv -----
// Front end: takes requests, clamps the byte count and folds in the data bytes.
module crcs_front
  import crcs_pkg::*;
#(
  parameter int BytesPerItem = BytesPerItemDef
) (
  input  logic                  push_i,
  input  logic                  queue_full_i,
  input  logic [DataWidth-1:0]  chunk_data_i,
  input  logic [CountWidth-1:0] byte_count_i,
  input  logic                  first_chunk_i,
  input  logic [31:0]           prior_crc_i,
  input  logic                  last_chunk_i,
  output logic                  item_push_o,
  output crcs_item_t            item_o
);

  logic [CountWidth-1:0] nbytes;
  logic [31:0]           dcrc;

  // Counts above the item size absorb a whole item; bytes above the count
  // are left out of the data CRC.
  always_comb begin
    nbytes = (byte_count_i > CountWidth'(BytesPerItem)) ?
             CountWidth'(BytesPerItem) : byte_count_i;
    dcrc = '0;
    for (int k = 0; k < BytesPerItem; k++) begin
      if (CountWidth'(k) < nbytes) begin
        dcrc = CrcTable[dcrc[7:0] ^ chunk_data_i[8*k +: 8]] ^ {8'h00, dcrc[31:8]};
      end
    end
  end

  assign item_push_o    = push_i && !queue_full_i;
  assign item_o.data_crc = dcrc;
  assign item_o.nbytes   = nbytes;
  assign item_o.first    = first_chunk_i;
  assign item_o.seed     = prior_crc_i ^ CrcInvert;
  assign item_o.last     = last_chunk_i;

endmodule

// ----- rtl/crcs_back.sv -----
// Back end: holds the running CRC register and combines it with each request.
module crcs_back
  import crcs_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         item_avail_i,
  input  crcs_item_t   item_i,
  output logic         item_pop_o,
  input  logic         res_full_i,
  output logic         res_push_o,
  output crcs_result_t res_o
);

  logic [31:0] running_q, running_d;
  logic [31:0] start;
  logic        advance;

  assign advance = item_avail_i && !res_full_i;

  // The CRC is linear: shifting the register over the item's bytes and
  // adding the data-only CRC gives the same as absorbing them one by one.
  always_comb begin
    start     = item_i.first ? item_i.seed : running_q;
    running_d = zero_shift(item_i.nbytes, start) ^ item_i.data_crc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= CrcInvert;
    end else if (advance) begin
      running_q <= running_d;
    end
  end

  assign item_pop_o = advance;
  assign res_push_o = advance;
  assign res_o.crc  = running_d ^ CrcInvert;
  assign res_o.last = item_i.last;

endmodule

// ----- rtl/crc32c_stream.sv -----
// Top level of the CRC-32C stream checksum block.
//
// Usage: requests enter through a queue-style port. A request is taken at a
// rising edge where push is high and full is low; it carries up to eight
// message bytes (first byte in the low bits), a byte count, a first-chunk
// mark with the prior CRC to extend, and a last-chunk mark. Every request
// yields exactly one result, the finalised CRC-32C of all bytes so far plus
// a copy of the last mark, offered on a second queue-style port: the oldest
// result sits on crc_value_o and is_last_o while empty is low and is taken
// at an edge where pop is also high.
// The request passes through the request queue and the back end into the
// result queue; empty falls once the result is written there, and pop takes it.
// Throughput is one request per cycle while the result queue has room, each
// request updating the running CRC register between the two queues.
// Reset empties both queues and loads the running register with all ones,
// as after a prior CRC of zero.
// When the receiver stops popping, the result queue fills first, then the
// request queue behind it, and full rises; no result is lost or repeated.
module crc32c_stream
  import crcs_pkg::*;
#(
  parameter int BytesPerItem = BytesPerItemDef,
  parameter int QueueDepth   = QueueDepthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  logic [DataWidth-1:0]  chunk_data_i,
  input  logic [CountWidth-1:0] byte_count_i,
  input  logic                  first_chunk_i,
  input  logic [31:0]           prior_crc_i,
  input  logic                  last_chunk_i,
  output logic                  empty,
  input  logic                  pop,
  output logic [31:0]           crc_value_o,
  output logic                  is_last_o
);

  localparam int ItemW   = $bits(crcs_item_t);
  localparam int ResultW = $bits(crcs_result_t);

  crcs_item_t   front_item;
  crcs_item_t   back_item;
  crcs_result_t back_res;
  crcs_result_t out_res;
  logic         front_push;
  logic         mid_full;
  logic         mid_empty;
  logic         mid_pop;
  logic         res_full;
  logic         res_push;

  // The front end works on the request as it arrives, so the heavy byte
  // folding sits ahead of the request queue and off the feedback path.
  crcs_front #(
    .BytesPerItem (BytesPerItem)
  ) u_front (
    .push_i        (push),
    .queue_full_i  (mid_full),
    .chunk_data_i  (chunk_data_i),
    .byte_count_i  (byte_count_i),
    .first_chunk_i (first_chunk_i),
    .prior_crc_i   (prior_crc_i),
    .last_chunk_i  (last_chunk_i),
    .item_push_o   (front_push),
    .item_o        (front_item)
  );

  assign full = mid_full;

  // Request queue between the two halves.
  crcs_fifo #(
    .Width (ItemW),
    .Depth (QueueDepth)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .data_i  (front_item),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .data_o  (back_item),
    .empty_o (mid_empty)
  );

  // The back end advances the running register once per request, only when
  // there is room for the result.
  crcs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_avail_i (!mid_empty),
    .item_i       (back_item),
    .item_pop_o   (mid_pop),
    .res_full_i   (res_full),
    .res_push_o   (res_push),
    .res_o        (back_res)
  );

  // Result queue: parts the back end from a stalling receiver.
  crcs_fifo #(
    .Width (ResultW),
    .Depth (QueueDepth)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (back_res),
    .full_o  (res_full),
    .pop_i   (pop && !empty),
    .data_o  (out_res),
    .empty_o (empty)
  );

  assign crc_value_o = out_res.crc;
  assign is_last_o   = out_res.last;

endmodule
